// ===== design/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg
// shared types, widths and field offsets for the spacecraft mode manager
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  localparam int RATE_WIDTH  = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int THR_W       = 32;
  localparam int MODE_W      = 3;
  localparam int LINK_W      = 4;
  localparam int CFG_INDEX_W = 1;

  localparam int MAX_W = (RATE_WIDTH > ANGLE_WIDTH) ? RATE_WIDTH : ANGLE_WIDTH;
  // sum of three squares fits in 2w+2 bits; kept wider than the threshold
  localparam int CMP_W = (2 * MAX_W + 2 > THR_W + 1) ? 2 * MAX_W + 2 : THR_W + 1;

  // input word layout, lowest bit first
  localparam int OFS_RATE_X   = 0;
  localparam int OFS_RATE_Y   = OFS_RATE_X + RATE_WIDTH;
  localparam int OFS_RATE_Z   = OFS_RATE_Y + RATE_WIDTH;
  localparam int OFS_ANGLE_X  = OFS_RATE_Z + RATE_WIDTH;
  localparam int OFS_ANGLE_Y  = OFS_ANGLE_X + ANGLE_WIDTH;
  localparam int OFS_ANGLE_Z  = OFS_ANGLE_Y + ANGLE_WIDTH;
  localparam int OFS_EST_OK   = OFS_ANGLE_Z + ANGLE_WIDTH;
  localparam int OFS_BAT_LOW  = OFS_EST_OK + 1;
  localparam int OFS_SCIENCE  = OFS_BAT_LOW + 1;
  localparam int OFS_LINK     = OFS_SCIENCE + 1;
  localparam int IN_BITS      = OFS_LINK + LINK_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((MODE_W + 7) / 8) * 8;

  localparam logic [THR_W-1:0] CAPTURE_RATE_SQ_RST   = THR_W'(41943);
  localparam logic [THR_W-1:0] POINTING_ERROR_SQ_RST = THR_W'(6711);

  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_RATE_SQ   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_POINTING_ERROR_SQ = 1'b1;

  // link flag bit positions
  localparam int LINK_GND     = 0;
  localparam int LINK_DL_DUE  = 1;
  localparam int LINK_UL_PEND = 2;
  localparam int LINK_UL_DONE = 3;

  typedef enum logic [MODE_W-1:0] {
    MD_SAFE     = 3'd0,
    MD_NOMINAL  = 3'd1,
    MD_DETUMBLE = 3'd2,
    MD_POINTING = 3'd3,
    MD_SCIENCE  = 3'd4,
    MD_DOWNLINK = 3'd5,
    MD_UPLINK   = 3'd6
  } mode_t;

  typedef struct packed {
    logic signed [RATE_WIDTH-1:0]  rate_x;
    logic signed [RATE_WIDTH-1:0]  rate_y;
    logic signed [RATE_WIDTH-1:0]  rate_z;
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
    logic signed [ANGLE_WIDTH-1:0] angle_z;
    logic                          estimate_ok;
    logic                          battery_low;
    logic                          science_pending;
    logic [LINK_W-1:0]             link_flags;
  } smm_item_t;

endpackage

`default_nettype wire

// ===== design/smm_next_mode.sv =====
// ----------------------------------------------------------------------------
// smm_next_mode
// magnitude checks and mode transition logic for one update tick
// ----------------------------------------------------------------------------
`default_nettype none

module smm_next_mode (
  input  wire smm_pkg::smm_item_t             item,
  input  wire smm_pkg::mode_t                 mode,
  input  wire logic [smm_pkg::THR_W-1:0]      capture_rate_sq,
  input  wire logic [smm_pkg::THR_W-1:0]      pointing_error_sq,
  output smm_pkg::mode_t                      mode_next
);

  localparam int RW2 = 2 * smm_pkg::RATE_WIDTH;
  localparam int AW2 = 2 * smm_pkg::ANGLE_WIDTH;
  localparam int CW  = smm_pkg::CMP_W;

  logic [RW2-1:0] sq_rx, sq_ry, sq_rz;
  logic [AW2-1:0] sq_ax, sq_ay, sq_az;
  logic [CW-1:0]  rate_sum, angle_sum, capture_thr, pointing_thr;
  logic           rate_low, rate_high, converged;
  logic           gnd, dl_due, ul_pend, ul_done, sci;

  assign sq_rx = $signed(item.rate_x) * $signed(item.rate_x);
  assign sq_ry = $signed(item.rate_y) * $signed(item.rate_y);
  assign sq_rz = $signed(item.rate_z) * $signed(item.rate_z);
  assign sq_ax = $signed(item.angle_x) * $signed(item.angle_x);
  assign sq_ay = $signed(item.angle_y) * $signed(item.angle_y);
  assign sq_az = $signed(item.angle_z) * $signed(item.angle_z);

  assign rate_sum  = {{(CW-RW2){1'b0}}, sq_rx} + {{(CW-RW2){1'b0}}, sq_ry}
                   + {{(CW-RW2){1'b0}}, sq_rz};
  assign angle_sum = {{(CW-AW2){1'b0}}, sq_ax} + {{(CW-AW2){1'b0}}, sq_ay}
                   + {{(CW-AW2){1'b0}}, sq_az};

  assign capture_thr  = {{(CW-smm_pkg::THR_W){1'b0}}, capture_rate_sq};
  assign pointing_thr = {{(CW-smm_pkg::THR_W){1'b0}}, pointing_error_sq};

  assign rate_low  = rate_sum < capture_thr;
  assign rate_high = rate_sum > capture_thr;
  assign converged = item.estimate_ok && (angle_sum < pointing_thr);

  assign gnd     = item.link_flags[smm_pkg::LINK_GND];
  assign dl_due  = item.link_flags[smm_pkg::LINK_DL_DUE];
  assign ul_pend = item.link_flags[smm_pkg::LINK_UL_PEND];
  assign ul_done = item.link_flags[smm_pkg::LINK_UL_DONE];
  assign sci     = item.science_pending;

  always_comb begin
    mode_next = mode;
    if (item.battery_low) begin
      mode_next = smm_pkg::MD_SAFE;
    end else begin
      unique case (mode)
        smm_pkg::MD_SAFE: begin
          mode_next = rate_low ? smm_pkg::MD_NOMINAL : smm_pkg::MD_DETUMBLE;
        end
        smm_pkg::MD_NOMINAL: begin
          if (rate_high) begin
            mode_next = smm_pkg::MD_DETUMBLE;
          end else if (gnd || sci) begin
            mode_next = smm_pkg::MD_POINTING;
          end
        end
        smm_pkg::MD_DETUMBLE: begin
          if (rate_low) begin
            mode_next = smm_pkg::MD_NOMINAL;
          end
        end
        smm_pkg::MD_POINTING: begin
          if (converged && sci) begin
            mode_next = smm_pkg::MD_SCIENCE;
          end else if (gnd && dl_due) begin
            mode_next = smm_pkg::MD_DOWNLINK;
          end else if (!sci && !gnd) begin
            mode_next = smm_pkg::MD_NOMINAL;
          end
        end
        smm_pkg::MD_SCIENCE: begin
          if (!sci) begin
            mode_next = smm_pkg::MD_NOMINAL;
          end else if (gnd && dl_due) begin
            mode_next = smm_pkg::MD_DOWNLINK;
          end
        end
        smm_pkg::MD_DOWNLINK: begin
          if (!gnd) begin
            mode_next = smm_pkg::MD_POINTING;
          end else if (ul_pend) begin
            mode_next = smm_pkg::MD_UPLINK;
          end
        end
        smm_pkg::MD_UPLINK: begin
          if (!gnd || ul_done) begin
            mode_next = smm_pkg::MD_NOMINAL;
          end
        end
        default: begin
          mode_next = smm_pkg::MD_SAFE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/spacecraft_mode_manager.sv =====
// ----------------------------------------------------------------------------
// spacecraft_mode_manager
// spacecraft mode sequencer driven by one estimator tick per input word
// ----------------------------------------------------------------------------
// Input stream s_*: one word per update tick with body rates, attitude errors
// and status flags. Output stream m_*: one word per tick holding the new mode.
// Config channel cfg_*: index 0 capture_rate_sq, index 1 pointing_error_sq;
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. An accepted word lands in an input
// register; the squares, threshold compares and mode transition sit between
// it and the result register, which also updates the held mode. m_tvalid
// rises once the word has passed both registers, and one word is taken every
// cycle while m_tready is high.
// When the receiver stalls the result holds and one more word can wait in the
// input register; s_tready then drops until the result is taken.
// Reset clears both stages, returns the held mode to safe and reloads the
// default thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module spacecraft_mode_manager (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // rate_x, rate_y, rate_z, angle_x, angle_y, angle_z, estimate_ok,
  // battery_low, science_pending, link_flags, zero pad
  input  wire logic [smm_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // new_mode, zero pad
  output logic [smm_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [smm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [smm_pkg::THR_W-1:0]        cfg_data
);

  localparam int RW = smm_pkg::RATE_WIDTH;
  localparam int AW = smm_pkg::ANGLE_WIDTH;

  smm_pkg::smm_item_t        in_item;
  smm_pkg::smm_item_t        s1_item;
  logic                      s1_valid;
  logic                      s1_adv;
  smm_pkg::mode_t            mode;
  smm_pkg::mode_t            mode_next;
  smm_pkg::mode_t            res_mode;
  logic                      out_valid;
  logic [smm_pkg::THR_W-1:0] capture_rate_sq;
  logic [smm_pkg::THR_W-1:0] pointing_error_sq;

  always_comb begin
    in_item.rate_x          = s_tdata[smm_pkg::OFS_RATE_X  +: RW];
    in_item.rate_y          = s_tdata[smm_pkg::OFS_RATE_Y  +: RW];
    in_item.rate_z          = s_tdata[smm_pkg::OFS_RATE_Z  +: RW];
    in_item.angle_x         = s_tdata[smm_pkg::OFS_ANGLE_X +: AW];
    in_item.angle_y         = s_tdata[smm_pkg::OFS_ANGLE_Y +: AW];
    in_item.angle_z         = s_tdata[smm_pkg::OFS_ANGLE_Z +: AW];
    in_item.estimate_ok     = s_tdata[smm_pkg::OFS_EST_OK];
    in_item.battery_low     = s_tdata[smm_pkg::OFS_BAT_LOW];
    in_item.science_pending = s_tdata[smm_pkg::OFS_SCIENCE];
    in_item.link_flags      = s_tdata[smm_pkg::OFS_LINK +: smm_pkg::LINK_W];
  end

  assign s1_adv    = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(smm_pkg::OUT_TDATA_W - smm_pkg::MODE_W){1'b0}}, res_mode};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_rate_sq   <= smm_pkg::CAPTURE_RATE_SQ_RST;
      pointing_error_sq <= smm_pkg::POINTING_ERROR_SQ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        smm_pkg::REG_CAPTURE_RATE_SQ:   capture_rate_sq   <= cfg_data;
        smm_pkg::REG_POINTING_ERROR_SQ: pointing_error_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= in_item;
    end
  end

  smm_next_mode u_next_mode (
    .item              (s1_item),
    .mode              (mode),
    .capture_rate_sq   (capture_rate_sq),
    .pointing_error_sq (pointing_error_sq),
    .mode_next         (mode_next)
  );

  // held mode and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= smm_pkg::MD_SAFE;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        mode <= mode_next;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_mode <= mode_next;
    end
  end

  a_result_is_held_mode : assert property (
    @(posedge clk) disable iff (rst) out_valid |-> (res_mode == mode)
  ) else $error("result word differs from held mode");

  a_battery_low_safe : assert property (
    @(posedge clk) disable iff (rst)
    (s1_adv && s1_item.battery_low) |=> (res_mode == smm_pkg::MD_SAFE)
  ) else $error("low battery did not force safe mode");

  a_advance_gives_result : assert property (
    @(posedge clk) disable iff (rst) s1_adv |=> out_valid
  ) else $error("advanced word produced no result");

endmodule

`default_nettype wire

// ===== tb/sv/tb_spacecraft_mode_manager.sv =====
// ----------------------------------------------------------------------------
// tb_spacecraft_mode_manager
// self-checking bench for the spacecraft mode sequencer
// ----------------------------------------------------------------------------
// Streams update ticks into the block and mirrors the mode sequencer, with its
// capture and pointing thresholds, to work out each new mode. The driver
// predicts at acceptance and the monitor compares every returned word with
// the oldest pending mode. A directed walk visits every mode, the battery
// override and both thresholds hit exactly. Random phases under several
// threshold settings, zero and all-ones among them, then follow, mostly with
// plausible ticks that wander through the deeper modes and partly with noise.
// ----------------------------------------------------------------------------
module tb_spacecraft_mode_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import smm_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 103;

  localparam logic [LINK_W-1:0] GND = LINK_W'(1 << LINK_GND);
  localparam logic [LINK_W-1:0] DL  = LINK_W'(1 << LINK_DL_DUE);
  localparam logic [LINK_W-1:0] UP  = LINK_W'(1 << LINK_UL_PEND);
  localparam logic [LINK_W-1:0] UD  = LINK_W'(1 << LINK_UL_DONE);

  typedef enum int {AXIS_ZERO, AXIS_TINY, AXIS_MEDIUM, AXIS_EQUAL, AXIS_FULL} axis_cls_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]       cfg_data = '0;

  smm_item_t        pending_ticks[$];
  mode_t            expected_modes[$];
  smm_item_t        on_bus;
  mode_t            held_mode = MD_SAFE;
  logic [THR_W-1:0] capture_thr = CAPTURE_RATE_SQ_RST;
  logic [THR_W-1:0] pointing_thr = POINTING_ERROR_SQ_RST;
  int               rate_eq[3];
  int               angle_eq[3];
  bit               steady = 1'b0;
  int               mismatches = 0;
  int               words_checked = 0;
  int               mode_hits[7];
  int               settings_used = 1;
  int               cycles = 0;

  spacecraft_mode_manager dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic mode_t next_mode(input mode_t cur, input smm_item_t t);
    longint rx, ry, rz, ax, ay, az;
    longint rate_mag, err_mag;
    bit     rate_low, rate_high, converged, gnd, dl_due;
    mode_t  nm;
    rx = t.rate_x;
    ry = t.rate_y;
    rz = t.rate_z;
    ax = t.angle_x;
    ay = t.angle_y;
    az = t.angle_z;
    rate_mag  = rx * rx + ry * ry + rz * rz;
    err_mag   = ax * ax + ay * ay + az * az;
    rate_low  = rate_mag < longint'(capture_thr);
    rate_high = rate_mag > longint'(capture_thr);
    converged = t.estimate_ok && (err_mag < longint'(pointing_thr));
    gnd       = t.link_flags[LINK_GND];
    dl_due    = t.link_flags[LINK_DL_DUE];
    nm = cur;
    if (t.battery_low) begin
      nm = MD_SAFE;
    end else begin
      case (cur)
        MD_SAFE: nm = rate_low ? MD_NOMINAL : MD_DETUMBLE;
        MD_NOMINAL: begin
          if (rate_high) nm = MD_DETUMBLE;
          else if (gnd || t.science_pending) nm = MD_POINTING;
        end
        MD_DETUMBLE: begin
          if (rate_low) nm = MD_NOMINAL;
        end
        MD_POINTING: begin
          if (converged && t.science_pending) nm = MD_SCIENCE;
          else if (gnd && dl_due) nm = MD_DOWNLINK;
          else if (!t.science_pending && !gnd) nm = MD_NOMINAL;
        end
        MD_SCIENCE: begin
          if (!t.science_pending) nm = MD_NOMINAL;
          else if (gnd && dl_due) nm = MD_DOWNLINK;
        end
        MD_DOWNLINK: begin
          if (!gnd) nm = MD_POINTING;
          else if (t.link_flags[LINK_UL_PEND]) nm = MD_UPLINK;
        end
        MD_UPLINK: begin
          if (!gnd || t.link_flags[LINK_UL_DONE]) nm = MD_NOMINAL;
        end
        default: nm = MD_SAFE;
      endcase
    end
    return nm;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_tick(input smm_item_t t);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[OFS_RATE_X  +: RATE_WIDTH]  = t.rate_x;
    w[OFS_RATE_Y  +: RATE_WIDTH]  = t.rate_y;
    w[OFS_RATE_Z  +: RATE_WIDTH]  = t.rate_z;
    w[OFS_ANGLE_X +: ANGLE_WIDTH] = t.angle_x;
    w[OFS_ANGLE_Y +: ANGLE_WIDTH] = t.angle_y;
    w[OFS_ANGLE_Z +: ANGLE_WIDTH] = t.angle_z;
    w[OFS_EST_OK]                 = t.estimate_ok;
    w[OFS_BAT_LOW]                = t.battery_low;
    w[OFS_SCIENCE]                = t.science_pending;
    w[OFS_LINK +: LINK_W]         = t.link_flags;
    return w;
  endfunction

  function automatic smm_item_t tick(input int rx, ry, rz, ax, ay, az,
                                     input bit est, bat, sci,
                                     input logic [LINK_W-1:0] lf);
    smm_item_t t;
    t.rate_x          = RATE_WIDTH'(rx);
    t.rate_y          = RATE_WIDTH'(ry);
    t.rate_z          = RATE_WIDTH'(rz);
    t.angle_x         = ANGLE_WIDTH'(ax);
    t.angle_y         = ANGLE_WIDTH'(ay);
    t.angle_z         = ANGLE_WIDTH'(az);
    t.estimate_ok     = est;
    t.battery_low     = bat;
    t.science_pending = sci;
    t.link_flags      = lf;
    return t;
  endfunction

  function automatic axis_cls_t pick_class(input bit noisy);
    int r;
    r = $urandom_range(99);
    if (noisy && r < 80) return AXIS_FULL;
    if (r < 10) return AXIS_ZERO;
    if (r < 45) return AXIS_TINY;
    if (r < 75) return AXIS_MEDIUM;
    if (r < 88) return AXIS_EQUAL;
    return AXIS_FULL;
  endfunction

  function automatic int axis_value(input axis_cls_t cls, input int tiny_lim, med_lim, eqv);
    case (cls)
      AXIS_ZERO:   return 0;
      AXIS_TINY:   return int'($urandom_range(2 * tiny_lim)) - tiny_lim;
      AXIS_MEDIUM: return int'($urandom_range(2 * med_lim)) - med_lim;
      AXIS_EQUAL:  return $urandom_range(1) ? eqv : -eqv;
      default:     return int'($urandom);
    endcase
  endfunction

  function automatic smm_item_t random_tick(input bit noisy);
    axis_cls_t rc, ac;
    rc = pick_class(noisy);
    ac = pick_class(noisy);
    return tick(axis_value(rc, 64, 300, rate_eq[0]),
                axis_value(rc, 64, 300, rate_eq[1]),
                axis_value(rc, 64, 300, rate_eq[2]),
                axis_value(ac, 30, 150, angle_eq[0]),
                axis_value(ac, 30, 150, angle_eq[1]),
                axis_value(ac, 30, 150, angle_eq[2]),
                noisy ? 1'($urandom) : ($urandom_range(99) < 85),
                noisy ? 1'($urandom) : ($urandom_range(99) < 4),
                1'($urandom),
                LINK_W'($urandom));
  endfunction

  // stream driver, predicts the new mode as each word is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        held_mode = next_mode(held_mode, on_bus);
        expected_modes.push_back(held_mode);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
          on_bus = pending_ticks.pop_front();
          s_tdata  <= pack_tick(on_bus);
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d at cycle %0d: %s", mismatches, cycles, msg);
  endtask

  // result monitor
  always @(posedge clk) begin
    mode_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_modes.size() == 0) begin
          report_mismatch($sformatf("word %h with no mode pending", m_tdata));
        end else begin
          want = expected_modes.pop_front();
          words_checked++;
          mode_hits[int'(want)]++;
          if (m_tdata !== OUT_TDATA_W'(want))
            report_mismatch($sformatf("new_mode expected %s (%0d), got word %h",
                                      want.name(), want, m_tdata));
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d modes still pending",
               cycles, expected_modes.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ticks.size() != 0 || s_tvalid || expected_modes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CAPTURE_RATE_SQ) capture_thr = val;
    else pointing_thr = val;
  endtask

  initial begin
    logic [THR_W-1:0] cap_val, pt_val;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed walk through every mode at reset thresholds
    pending_ticks.push_back(tick(-32768, 32767, -32768, 32767, -32768, 32767, 1, 0, 1,
                                 GND | DL | UP | UD));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, GND));
    pending_ticks.push_back(tick(10, -10, 5, 0, 0, 0, 1, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 1, 0, 1, GND | DL));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, GND));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, GND | UP));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, GND | UD));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 1, GND | DL));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(0, 0, 0, 100, 100, 100, 1, 0, 1, GND));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(32767, 32767, 32767, 0, 0, 0, 0, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, GND | DL));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, GND | UP));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, UD));
    drain();

    // both magnitudes landing exactly on their thresholds
    write_reg(REG_CAPTURE_RATE_SQ, THR_W'(3 * 100 * 100));
    write_reg(REG_POINTING_ERROR_SQ, THR_W'(3 * 50 * 50));
    settings_used++;
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 1, 0, '0));
    pending_ticks.push_back(tick(100, -100, 100, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(-100, 100, 100, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(-100, 100, -100, 0, 0, 0, 0, 0, 0, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 50, -50, 50, 1, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 50, -50, 49, 1, 0, 1, '0));
    pending_ticks.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < 3; i++) begin
        rate_eq[i]  = int'($urandom_range(500)) - 250;
        angle_eq[i] = int'($urandom_range(180)) - 90;
      end
      case (ph)
        0: begin
          cap_val = CAPTURE_RATE_SQ_RST;
          pt_val  = POINTING_ERROR_SQ_RST;
        end
        2: begin
          cap_val = '0;
          pt_val  = '1;
        end
        4: begin
          cap_val = '1;
          pt_val  = '0;
        end
        6: begin
          cap_val = '1;
          pt_val  = '1;
        end
        default: begin
          cap_val = THR_W'(rate_eq[0] * rate_eq[0] + rate_eq[1] * rate_eq[1] +
                           rate_eq[2] * rate_eq[2]);
          pt_val  = THR_W'(angle_eq[0] * angle_eq[0] + angle_eq[1] * angle_eq[1] +
                           angle_eq[2] * angle_eq[2]);
        end
      endcase
      write_reg(REG_CAPTURE_RATE_SQ, cap_val);
      write_reg(REG_POINTING_ERROR_SQ, pt_val);
      settings_used++;
      steady = (ph == 3);
      for (int n = 0; n < PHASE_TICKS; n++)
        pending_ticks.push_back(random_tick($urandom_range(99) < 25));
      drain();
    end

    $display("checked %0d mode words under %0d threshold settings",
             words_checked, settings_used);
    $display("modes seen: safe %0d nominal %0d detumble %0d pointing %0d science %0d"
             , mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
    $display("modes seen: downlink %0d uplink %0d, mismatches %0d",
             mode_hits[5], mode_hits[6], mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
